FILE: hw/rtl/ffa_pkg.sv
// Shared types, constants and helpers of the first-fit allocator.
`default_nettype none
package ffa_pkg;

   localparam int HEAP_MAX_BYTES = 65536;
   localparam int WORD_BYTES     = 8;
   localparam int HEADER_BYTES   = 16;
   localparam int STORE_DEPTH    = (HEAP_MAX_BYTES + WORD_BYTES - 1) / WORD_BYTES;

   localparam int OFF_W   = $clog2(HEAP_MAX_BYTES);
   localparam int WSH     = $clog2(WORD_BYTES);
   localparam int SLOT_W  = $clog2(STORE_DEPTH);
   localparam int VIS_W   = SLOT_W + 1;
   localparam int HEAP_W  = 17;
   localparam int REQ_W   = 17;
   localparam int RSIZE_W = REQ_W + 1;

   localparam logic [HEAP_W-1:0] HEAP_RESET = HEAP_W'(65536);
   localparam logic [RSIZE_W-1:0] SPLIT_MIN = RSIZE_W'(HEADER_BYTES + WORD_BYTES);

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct packed {
      logic [OFF_W-1:0] size;
      logic [OFF_W-1:0] next;
      logic             has_next;
   } hdr_type;

   typedef struct packed {
      logic             valid;
      logic [OFF_W-1:0] size;
   } build_type;

   function automatic build_type heap_build(input logic [HEAP_W-1:0] bytes);
      logic [HEAP_W:0] eff;
      logic [HEAP_W:0] sz;
      build_type       res;
      eff = {1'b0, bytes};
      if (eff > (HEAP_W+1)'(HEAP_MAX_BYTES)) begin
         eff = (HEAP_W+1)'(HEAP_MAX_BYTES);
      end
      sz        = eff - (HEAP_W+1)'(HEADER_BYTES);
      res.valid = (eff >= (HEAP_W+1)'(HEADER_BYTES));
      res.size  = sz[OFF_W-1:0];
      return res;
   endfunction

   function automatic logic [RSIZE_W-1:0] round_up(input logic [REQ_W-1:0] req);
      logic [RSIZE_W-1:0] s;
      s = {1'b0, req} + RSIZE_W'(WORD_BYTES - 1);
      s[WSH-1:0] = '0;
      return s;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] off);
      return off[WSH +: SLOT_W];
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ffa_if.sv
// Request and response channel interfaces of the first-fit allocator.
`default_nettype none
interface ffa_req_if
   import ffa_pkg::*;
;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [REQ_W-1:0]   request_bytes;
   logic [OFF_W-1:0]   free_offset;

   modport source (output valid, kind, request_bytes, free_offset, input ready);
   modport sink   (input valid, kind, request_bytes, free_offset, output ready);
endinterface

interface ffa_rsp_if
   import ffa_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [OFF_W-1:0]   data_offset;
   logic               ok;

   modport source (output valid, data_offset, ok, input ready);
   modport sink   (input valid, data_offset, ok, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/first_fit_free_list_allocator_core.sv
// First-fit free-list heap allocator: sequencer, header store and result register.
//
// Usage:
//  req_chan (valid/ready) carries one item: kind 0 allocates request_bytes,
//  kind 1 releases the block whose data starts at free_offset.
//  rsp_chan (valid/ready) returns one item per request: data_offset and ok.
//  csr_we/csr_wdata write the heap size; write only while no item is in flight.
//  The write rebuilds the heap as one free block at offset 0.
//  Free: header read, header write, then the result state before rsp valid.
//  Allocate: a walk step and a header check per visited free block, then a
//  rest-header write for a split and a read and write of the previous header
//  when the taken block is not the list head; a failed allocate ends in a
//  walk step. The header store gives one header read per visited block.
//  One item at a time: req ready is high only while the sequencer is idle,
//  from the cycle after the result is loaded.
//  A finished item waits in the output register; a stalled receiver holds
//  the sequencer before it loads the next result.
//  Reset (synchronous, active high) sets the heap to 65536 bytes, one free
//  block, and writes its header; the header store has no other clearing.
`default_nettype none
module first_fit_free_list_allocator_core
   import ffa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [HEAP_W-1:0] csr_wdata,
   ffa_req_if.sink                req_chan,
   ffa_rsp_if.source              rsp_chan
);

   typedef enum logic [3:0] {
      S_IDLE, S_FREE_RD, S_FREE_WR, S_WALK, S_CHECK,
      S_WR_REST, S_RD_PREV, S_WR_PREV, S_RESP
   } state_type;

   state_type          state_ff;
   logic [OFF_W-1:0]   head_ff;
   logic               head_valid_ff;
   logic [OFF_W-1:0]   cur_ff;
   logic               cur_valid_ff;
   logic [OFF_W-1:0]   prev_ff;
   logic               at_head_ff;
   logic [VIS_W-1:0]   visits_ff;
   logic [RSIZE_W-1:0] rsize_ff;
   logic [OFF_W-1:0]   succ_ff;
   logic               succ_valid_ff;
   logic [OFF_W-1:0]   rest_ff;
   logic [OFF_W-1:0]   split_ptr_ff;
   logic [OFF_W-1:0]   q_ff;
   logic [OFF_W-1:0]   res_off_ff;
   logic               res_ok_ff;
   logic               rsp_valid_ff;
   logic [OFF_W-1:0]   rsp_off_ff;
   logic               rsp_ok_ff;

   hdr_type            mem [STORE_DEPTH];
   hdr_type            rd_ff;
   logic               mem_we;
   logic [SLOT_W-1:0]  mem_waddr;
   hdr_type            mem_wdata;
   logic [SLOT_W-1:0]  mem_raddr;

   build_type          build_rst;
   build_type          build_csr;
   logic               hit;
   logic [RSIZE_W-1:0] remain;
   logic               split;
   logic [OFF_W-1:0]   split_ptr;
   logic [OFF_W-1:0]   rest;
   logic               req_fire;

   assign build_rst = heap_build(HEAP_RESET);
   assign build_csr = heap_build(csr_wdata);
   assign req_fire  = req_chan.valid && req_chan.ready;

   assign hit       = {{(RSIZE_W-OFF_W){1'b0}}, rd_ff.size} >= rsize_ff;
   assign remain    = {{(RSIZE_W-OFF_W){1'b0}}, rd_ff.size} - rsize_ff;
   assign split     = hit && (remain >= SPLIT_MIN);
   assign split_ptr = cur_ff + OFF_W'(HEADER_BYTES) + rsize_ff[OFF_W-1:0];
   assign rest      = remain[OFF_W-1:0] - OFF_W'(HEADER_BYTES);

   // header store port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_of(cur_ff);
      mem_wdata = '{size: rd_ff.size, next: succ_ff, has_next: succ_valid_ff};
      mem_raddr = slot_of(cur_ff);
      case (state_ff)
         S_FREE_RD: begin
            mem_raddr = slot_of(q_ff);
         end
         S_FREE_WR: begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(q_ff);
            mem_wdata = '{size: rd_ff.size, next: head_ff, has_next: head_valid_ff};
         end
         S_CHECK: begin
            if (split) begin
               mem_we    = 1'b1;
               mem_wdata = '{size: rsize_ff[OFF_W-1:0], next: rd_ff.next,
                             has_next: rd_ff.has_next};
            end
         end
         S_WR_REST: begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(split_ptr_ff);
            mem_wdata = '{size: rest_ff, next: succ_ff, has_next: succ_valid_ff};
         end
         S_RD_PREV: begin
            mem_raddr = slot_of(prev_ff);
         end
         S_WR_PREV: begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(prev_ff);
         end
         default: begin
         end
      endcase
      if (reset) begin
         mem_we    = 1'b1;
         mem_waddr = '0;
         mem_wdata = '{size: build_rst.size, next: '0, has_next: 1'b0};
      end else if (csr_we) begin
         mem_we    = build_csr.valid;
         mem_waddr = '0;
         mem_wdata = '{size: build_csr.size, next: '0, has_next: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         head_valid_ff <= build_rst.valid;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            head_ff       <= '0;
            head_valid_ff <= build_csr.valid;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_chan.kind == KIND_FREE) begin
                     q_ff       <= req_chan.free_offset - OFF_W'(HEADER_BYTES);
                     res_off_ff <= req_chan.free_offset;
                     res_ok_ff  <= 1'b1;
                     state_ff   <= S_FREE_RD;
                  end else begin
                     rsize_ff     <= round_up(req_chan.request_bytes);
                     cur_ff       <= head_ff;
                     cur_valid_ff <= head_valid_ff;
                     at_head_ff   <= 1'b1;
                     visits_ff    <= '0;
                     state_ff     <= S_WALK;
                  end
               end
            end
            S_FREE_RD: begin
               state_ff <= S_FREE_WR;
            end
            S_FREE_WR: begin
               head_ff       <= q_ff;
               head_valid_ff <= 1'b1;
               state_ff      <= S_RESP;
            end
            S_WALK: begin
               if (!cur_valid_ff || visits_ff[SLOT_W]) begin
                  res_off_ff <= '0;
                  res_ok_ff  <= 1'b0;
                  state_ff   <= S_RESP;
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (hit) begin
                  res_off_ff    <= cur_ff + OFF_W'(HEADER_BYTES);
                  res_ok_ff     <= 1'b1;
                  succ_ff       <= rd_ff.next;
                  succ_valid_ff <= rd_ff.has_next;
                  if (split) begin
                     split_ptr_ff <= split_ptr;
                     rest_ff      <= rest;
                     state_ff     <= S_WR_REST;
                  end else if (at_head_ff) begin
                     head_ff       <= rd_ff.next;
                     head_valid_ff <= rd_ff.has_next;
                     state_ff      <= S_RESP;
                  end else begin
                     state_ff <= S_RD_PREV;
                  end
               end else begin
                  prev_ff      <= cur_ff;
                  at_head_ff   <= 1'b0;
                  cur_ff       <= rd_ff.next;
                  cur_valid_ff <= rd_ff.has_next;
                  visits_ff    <= visits_ff + VIS_W'(1);
                  state_ff     <= S_WALK;
               end
            end
            S_WR_REST: begin
               succ_ff       <= split_ptr_ff;
               succ_valid_ff <= 1'b1;
               if (at_head_ff) begin
                  head_ff       <= split_ptr_ff;
                  head_valid_ff <= 1'b1;
                  state_ff      <= S_RESP;
               end else begin
                  state_ff <= S_RD_PREV;
               end
            end
            S_RD_PREV: begin
               state_ff <= S_WR_PREV;
            end
            S_WR_PREV: begin
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_off_ff   <= res_off_ff;
                  rsp_ok_ff    <= res_ok_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.data_offset = rsp_off_ff;
   assign rsp_chan.ok          = rsp_ok_ff;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ok) |-> (rsp_chan.data_offset == '0))
      else $error("failed allocation with nonzero offset");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !csr_we) |-> !mem_we)
      else $error("header store written while idle");

   a_visit_bound: assert property (@(posedge clock) disable iff (reset)
      visits_ff[SLOT_W] |-> (visits_ff[SLOT_W-1:0] == '0))
      else $error("list walk exceeded store depth");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("second item taken while busy");

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the first-fit free-list allocator: random and directed items against a scoreboard.
`timescale 1ns / 1ps
module tb_top
   import ffa_pkg::*;
;

   localparam int ITEM_TARGET  = 1400;
   localparam int WALK_CAP     = 128;
   localparam int CFG_SETTLE   = 8;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      logic [OFF_W-1:0] offset;
      logic             ok;
   } grant_type;

   class alloc_scoreboard;
      logic [OFF_W-1:0] blk_size [STORE_DEPTH];
      logic [OFF_W-1:0] blk_next [STORE_DEPTH];
      bit               blk_linked [STORE_DEPTH];
      bit               size_known [STORE_DEPTH];
      logic [OFF_W-1:0] head;
      bit               head_valid;
      grant_type        grants[$];
      grant_type        last_grant;
      int               errors;

      function new();
         errors = 0;
         foreach (size_known[i]) begin
            size_known[i] = 1'b0;
            blk_linked[i] = 1'b0;
         end
         rebuild(HEAP_RESET);
      endfunction

      function int entry_of(int off);
         return (off / WORD_BYTES) % STORE_DEPTH;
      endfunction

      function int round_bytes(logic [REQ_W-1:0] nbytes);
         return ((int'(nbytes) + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
      endfunction

      function void rebuild(logic [HEAP_W-1:0] bytes);
         int eff;
         eff = int'(bytes);
         if (eff > HEAP_MAX_BYTES) begin
            eff = HEAP_MAX_BYTES;
         end
         head       = '0;
         head_valid = (eff >= HEADER_BYTES);
         if (head_valid) begin
            blk_size[0]   = OFF_W'(eff - HEADER_BYTES);
            blk_next[0]   = '0;
            blk_linked[0] = 1'b0;
            size_known[0] = 1'b1;
         end
      endfunction

      // number of free blocks an allocate of need bytes would visit
      function int walk_length(int need);
         int cur;
         int n;
         bit live;
         cur  = int'(head);
         live = head_valid;
         n    = 0;
         while (live && n < STORE_DEPTH) begin
            n++;
            if (int'(blk_size[entry_of(cur)]) >= need) begin
               return n;
            end
            live = blk_linked[entry_of(cur)];
            cur  = int'(blk_next[entry_of(cur)]);
         end
         return n;
      endfunction

      function void note_request(bit kind, logic [REQ_W-1:0] nbytes, logic [OFF_W-1:0] foff);
         grant_type g;
         int     need, cur, prev, n, e, p, succ, rest;
         bit     live, at_head, succ_live, done;
         g.offset = '0;
         g.ok     = 1'b0;
         if (kind == KIND_FREE) begin
            cur           = (int'(foff) + HEAP_MAX_BYTES - HEADER_BYTES) % HEAP_MAX_BYTES;
            e             = entry_of(cur);
            blk_next[e]   = head;
            blk_linked[e] = head_valid;
            head          = OFF_W'(cur);
            head_valid    = 1'b1;
            g.offset      = foff;
            g.ok          = 1'b1;
         end else begin
            need    = round_bytes(nbytes);
            cur     = int'(head);
            live    = head_valid;
            prev    = 0;
            at_head = 1'b1;
            n       = 0;
            done    = 1'b0;
            while (live && n < STORE_DEPTH && !done) begin
               e = entry_of(cur);
               n++;
               if (int'(blk_size[e]) >= need) begin
                  succ      = int'(blk_next[e]);
                  succ_live = blk_linked[e];
                  if (int'(blk_size[e]) - need >= HEADER_BYTES + WORD_BYTES) begin
                     p           = (cur + HEADER_BYTES + need) % HEAP_MAX_BYTES;
                     rest        = int'(blk_size[e]) - need - HEADER_BYTES;
                     blk_size[e] = OFF_W'(need);
                     blk_size[entry_of(p)]   = OFF_W'(rest);
                     blk_next[entry_of(p)]   = OFF_W'(succ);
                     blk_linked[entry_of(p)] = succ_live;
                     size_known[entry_of(p)] = 1'b1;
                     succ      = p;
                     succ_live = 1'b1;
                  end
                  if (at_head) begin
                     head       = OFF_W'(succ);
                     head_valid = succ_live;
                  end else begin
                     blk_next[entry_of(prev)]   = OFF_W'(succ);
                     blk_linked[entry_of(prev)] = succ_live;
                  end
                  g.offset = OFF_W'(cur + HEADER_BYTES);
                  g.ok     = 1'b1;
                  done     = 1'b1;
               end else begin
                  prev    = cur;
                  at_head = 1'b0;
                  live    = blk_linked[e];
                  cur     = int'(blk_next[e]);
               end
            end
         end
         last_grant = g;
         grants.push_back(g);
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_grant(logic [OFF_W-1:0] offset, logic ok);
         grant_type g;
         if (grants.size() == 0) begin
            report($sformatf("response with nothing pending: offset=%0d ok=%0b", offset, ok));
            return;
         end
         g = grants.pop_front();
         if (ok !== g.ok) begin
            report($sformatf("ok: got %0b, want %0b", ok, g.ok));
         end
         if (offset !== g.offset) begin
            report($sformatf("data_offset: got %0d, want %0d", offset, g.offset));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [HEAP_W-1:0] csr_wdata;

   ffa_req_if req_bus ();
   ffa_rsp_if rsp_bus ();

   alloc_scoreboard sb;
   bit              no_idle;
   bit              hold_request;
   int              sent;
   int              live_offsets[$];

   first_fit_free_list_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // result receiver
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold         = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= (no_idle || $urandom_range(99) >= 31);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_grant(rsp_bus.data_offset, rsp_bus.ok);
      end
   end

   task automatic send_item(bit kind, logic [REQ_W-1:0] nbytes, logic [OFF_W-1:0] foff);
      while (!no_idle && $urandom_range(99) < 31) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= kind;
      req_bus.request_bytes <= nbytes;
      req_bus.free_offset   <= foff;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      sb.note_request(kind, nbytes, foff);
   endtask

   task automatic write_heap(logic [HEAP_W-1:0] bytes);
      req_bus.valid <= 1'b0;
      while (sb.grants.size() != 0) begin
         @(posedge clock);
      end
      repeat (CFG_SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= bytes;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.rebuild(bytes);
   endtask

   task automatic run_directed();
      send_item(KIND_ALLOC, 17'd0, '0);
      send_item(KIND_ALLOC, 17'd1, '0);
      send_item(KIND_ALLOC, 17'd65536, '0);
      send_item(KIND_ALLOC, 17'd65535, '1);
      send_item(KIND_FREE, '1, 16'd32);
      send_item(KIND_ALLOC, 17'd8, '0);
      send_item(KIND_ALLOC, 17'd24, '0);
      // double free leaves a self loop; a large request then walks it to the cap
      send_item(KIND_FREE, '0, 16'd32);
      send_item(KIND_FREE, '0, 16'd32);
      send_item(KIND_ALLOC, 17'd65536, '0);
      send_item(KIND_ALLOC, 17'd8, '0);
      send_item(KIND_FREE, '0, 16'd35);
      send_item(KIND_ALLOC, 17'd0, '0);
      // header wraps below zero; list is rebuilt before any walk
      send_item(KIND_FREE, '0, 16'd5);
      write_heap(17'h1FFFF);
      send_item(KIND_ALLOC, 17'd65480, '0);
      send_item(KIND_ALLOC, 17'd65536, '0);
      write_heap(17'd0);
      send_item(KIND_ALLOC, 17'd0, '0);
      send_item(KIND_FREE, '0, 16'd16);
      send_item(KIND_ALLOC, 17'd16, '0);
      write_heap(17'd32);
      send_item(KIND_ALLOC, 17'd16, '0);
      send_item(KIND_ALLOC, 17'd0, '0);
      send_item(KIND_FREE, '0, 16'hFFFF);
   endtask

   task automatic run_phase(logic [HEAP_W-1:0] heap, int count, bit squeeze);
      int               pick, idx, e, s, tries, r;
      bit               kind;
      logic [REQ_W-1:0] nbytes;
      logic [OFF_W-1:0] foff;
      write_heap(heap);
      live_offsets.delete();
      if (squeeze) begin
         hold_request = 1'b1;
      end
      repeat (count) begin
         pick   = $urandom_range(99);
         kind   = KIND_ALLOC;
         nbytes = REQ_W'($urandom);
         foff   = OFF_W'($urandom);
         if (pick < 40 && live_offsets.size() > 0) begin
            idx  = $urandom_range(live_offsets.size() - 1);
            foff = OFF_W'(live_offsets[idx]);
            live_offsets.delete(idx);
            kind = KIND_FREE;
         end else if (pick >= 95) begin
            // stray free: misaligned, stale or repeated, but on a written header
            e = 0;
            for (tries = 0; tries < 32 && e == 0; tries++) begin
               s = $urandom_range(STORE_DEPTH - 1);
               if (sb.size_known[s]) begin
                  e = s;
               end
            end
            foff = OFF_W'(e * WORD_BYTES + $urandom_range(WORD_BYTES - 1) + HEADER_BYTES);
            kind = KIND_FREE;
         end else begin
            r = $urandom_range(99);
            if (r < 45) begin
               nbytes = REQ_W'($urandom_range(64));
            end else if (r < 70) begin
               nbytes = REQ_W'($urandom_range(1024));
            end else if (r < 85) begin
               nbytes = REQ_W'($urandom_range(16384));
            end else if (r < 95) begin
               nbytes = REQ_W'($urandom_range(65536));
            end else begin
               case ($urandom_range(3))
                  0: nbytes = REQ_W'(0);
                  1: nbytes = REQ_W'(1);
                  2: nbytes = REQ_W'(65535);
                  default: nbytes = REQ_W'(65536);
               endcase
            end
            if (sb.walk_length(sb.round_bytes(nbytes)) > WALK_CAP) begin
               nbytes = '0;
            end
         end
         send_item(kind, nbytes, foff);
         if (kind == KIND_ALLOC && sb.last_grant.ok) begin
            live_offsets.push_back(int'(sb.last_grant.offset));
         end
         sent++;
      end
   endtask

   initial begin
      int               phase;
      logic [HEAP_W-1:0] heap;
      sb           = new();
      no_idle      = 1'b0;
      hold_request = 1'b0;
      sent         = 0;
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_wdata             <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.kind          <= KIND_ALLOC;
      req_bus.request_bytes <= '0;
      req_bus.free_offset   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      phase = 0;
      while (sent < ITEM_TARGET) begin
         case (phase)
            0: heap = HEAP_W'(HEAP_MAX_BYTES);
            1: heap = HEAP_W'(32);
            default: begin
               case ($urandom_range(2))
                  0: heap = HEAP_W'(HEAP_MAX_BYTES);
                  1: heap = HEAP_W'($urandom_range(32, 65536));
                  default: heap = HEAP_W'($urandom_range(32, 2048));
               endcase
            end
         endcase
         no_idle = (phase == 2);
         run_phase(heap, $urandom_range(80, 200), phase == 3);
         no_idle = 1'b0;
         phase++;
      end

      req_bus.valid <= 1'b0;
      while (sb.grants.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
